FILE: hdl/mslbs_pkg.sv
// Shared types and codes for the multi-slot bounded list store.
package mslbs_pkg;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_APPEND  = 3'd1,
		OP_DROP    = 3'd2,
		OP_DELETE  = 3'd3,
		OP_RESIZE  = 3'd4,
		OP_COUNT   = 3'd5,
		OP_READ    = 3'd6,
		OP_RSORTED = 3'd7
	} opcode_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_BAD_POS      = 4'd1,
		ST_BAD_SIZE     = 4'd2,
		ST_EXISTS       = 4'd3,
		ST_NO_MEM       = 4'd4,
		ST_FULL         = 4'd5,
		ST_NO_STRUCT    = 4'd6,
		ST_EMPTY        = 4'd7,
		ST_NOT_FOUND    = 4'd8,
		ST_BAD_NEW_SIZE = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		SCAN_FIND,
		SCAN_SHIFT,
		SCAN_SORT
	} scan_mode_t;

	localparam int OPCODE_W  = 3;
	localparam int SLOT_W    = 4;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 4;

endpackage

FILE: hdl/mslbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mslbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/multi_slot_bounded_list_store.sv
// Top level of the multi-slot bounded list store: slot table, sequencer and element RAM.
//
// Usage: one item on the s_ channel carries one operation (create, append, drop last,
// delete value, resize, count, read, read sorted) on a 1-based slot. Every item gives
// one or more results on the m_ channel; the final result of an item has m_tlast high.
// Reads of a non-empty list give one result per element.
// Slot capacities and counts sit in flip-flops; the elements sit in one RAM of
// NUM_SLOTS*SLOT_MAX_CAPACITY words with one write and one registered read port.
// Items are taken one at a time: s_tready is high only while the sequencer is idle.
// Sequence: a single-result operation passes through S_EXEC and S_EMIT to the output
// register. Delete scans the list through the RAM read port and then shifts the tail
// down. A plain read issues one RAM read per element (S_RD_ISSUE, S_RD_DATA, S_EMIT).
// A sorted read does a selection pass over the list per output element through the
// single RAM read port.
// Reset empties every slot; the element RAM is not cleared, as no word is read
// before an append has written it.
// A stalled receiver holds the output register; the sequencer waits for it to
// drain before it places the next result.
module multi_slot_bounded_list_store #(
	parameter int NUM_SLOTS         = 10,
	parameter int SLOT_MAX_CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [3:0] slot, [35:4] operand, [39:36] zero
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data
	output logic [4:0]  m_tuser,   // [3:0] status, [4] data_valid
	output logic        m_tlast
);

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = $clog2(SLOT_MAX_CAPACITY + 1);
	localparam int DEPTH = NUM_SLOTS * SLOT_MAX_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [33:0] MAX34 = 34'(SLOT_MAX_CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RD_ISSUE,
		S_RD_DATA,
		S_EMIT
	} state_t;

	state_t                       state_q, res_next_q;
	mslbs_pkg::opcode_t           op_q;
	logic [mslbs_pkg::SLOT_W-1:0] slot_q;
	logic [31:0]                  opnd_q;

	logic          present_q [NUM_SLOTS];
	logic [CW-1:0] cap_q     [NUM_SLOTS];
	logic [CW-1:0] cnt_meta_q[NUM_SLOTS];

	logic [AW-1:0]        base_q;
	logic [CW-1:0]        cnt_q, j_q, k_q, ridx_s1, fidx_q, best_idx_q, prev_idx_q;
	logic                 rv_s1, found_q, first_q;
	logic [31:0]          best_v_q, prev_v_q;
	mslbs_pkg::scan_mode_t mode_q;

	mslbs_pkg::status_t res_status_q;
	logic [31:0]        res_data_q;
	logic               res_dv_q, res_last_q;

	logic               m_tvalid_q, m_tlast_q;
	logic [31:0]        m_tdata_q;
	logic [4:0]         m_tuser_q;

	// current slot view
	logic          pos_ok, present_cur;
	logic [SW-1:0] sidx;
	logic [CW-1:0] cap_cur, cnt_cur;
	logic [AW-1:0] base_cur;
	logic signed [33:0] nc;
	logic          app_ok;

	// decode of the operation held in op_q
	mslbs_pkg::status_t exec_status;
	state_t             exec_next;
	logic               exec_count;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic signed [31:0] rd_s, best_s, prev_s;
	logic               cand, better, out_free;

	assign pos_ok      = (slot_q != '0) && (32'(slot_q) <= 32'(NUM_SLOTS));
	assign sidx        = SW'(slot_q - 4'd1);
	assign present_cur = present_q[sidx];
	assign cap_cur     = cap_q[sidx];
	assign cnt_cur     = cnt_meta_q[sidx];
	assign base_cur    = AW'(sidx) * AW'(SLOT_MAX_CAPACITY);
	assign nc          = $signed({{(34-CW){1'b0}}, cap_cur}) + $signed({{2{opnd_q[31]}}, opnd_q});
	assign app_ok      = pos_ok && (op_q == mslbs_pkg::OP_APPEND) && present_cur
	                     && (cnt_cur < cap_cur);

	assign rd_s   = $signed(ram_rdata);
	assign best_s = $signed(best_v_q);
	assign prev_s = $signed(prev_v_q);
	// next in (value, index) order after the previous output; stable like insertion sort
	assign cand   = first_q || (rd_s > prev_s) || ((rd_s == prev_s) && (ridx_s1 > prev_idx_q));
	assign better = !found_q || (rd_s < best_s);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		exec_status = mslbs_pkg::ST_OK;
		exec_next   = S_EMIT;
		exec_count  = 1'b0;
		if (!pos_ok) begin
			exec_status = mslbs_pkg::ST_BAD_POS;
		end else if (op_q == mslbs_pkg::OP_CREATE) begin
			if ($signed(opnd_q) < 32'sd1) begin
				exec_status = mslbs_pkg::ST_BAD_SIZE;
			end else if (present_cur) begin
				exec_status = mslbs_pkg::ST_EXISTS;
			end else if ($signed(opnd_q) > 32'(SLOT_MAX_CAPACITY)) begin
				exec_status = mslbs_pkg::ST_NO_MEM;
			end
		end else if (!present_cur) begin
			exec_status = mslbs_pkg::ST_NO_STRUCT;
		end else begin
			case (op_q)
				mslbs_pkg::OP_APPEND: begin
					if (!app_ok) begin
						exec_status = mslbs_pkg::ST_FULL;
					end
				end
				mslbs_pkg::OP_DROP: begin
					if (cnt_cur == '0) begin
						exec_status = mslbs_pkg::ST_EMPTY;
					end
				end
				mslbs_pkg::OP_DELETE: begin
					if (cnt_cur == '0) begin
						exec_status = mslbs_pkg::ST_NOT_FOUND;
					end else begin
						exec_next = S_SCAN;
					end
				end
				mslbs_pkg::OP_RESIZE: begin
					if (nc < 34'sd1) begin
						exec_status = mslbs_pkg::ST_BAD_NEW_SIZE;
					end else if (nc > MAX34) begin
						exec_status = mslbs_pkg::ST_NO_MEM;
					end
				end
				mslbs_pkg::OP_COUNT: begin
					exec_count = 1'b1;
				end
				default: begin
					if (cnt_cur != '0) begin
						exec_next = (op_q == mslbs_pkg::OP_RSORTED) ? S_SCAN : S_RD_ISSUE;
					end
				end
			endcase
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base_cur + AW'(cnt_cur);
		ram_wdata = opnd_q;
		ram_re    = 1'b0;
		ram_raddr = base_q + AW'(j_q);
		unique case (state_q)
			S_EXEC: begin
				ram_we = app_ok;
			end
			S_SCAN: begin
				ram_re = (j_q < cnt_q);
				if ((mode_q == mslbs_pkg::SCAN_SHIFT) && rv_s1) begin
					ram_we    = 1'b1;
					ram_waddr = base_q + AW'(ridx_s1) - AW'(1);
					ram_wdata = ram_rdata;
				end
			end
			S_RD_ISSUE: begin
				ram_re    = 1'b1;
				ram_raddr = base_q + AW'(k_q);
			end
			default: begin
			end
		endcase
	end

	mslbs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_elem_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_next_q <= S_IDLE;
			m_tvalid_q <= 1'b0;
			rv_s1      <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				present_q[i]  <= 1'b0;
				cap_q[i]      <= '0;
				cnt_meta_q[i] <= '0;
			end
		end else begin
			if ((state_q == S_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			rv_s1 <= (state_q == S_SCAN) && (j_q < cnt_q);
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= mslbs_pkg::opcode_t'(s_tuser);
						slot_q  <= s_tdata[3:0];
						opnd_q  <= s_tdata[35:4];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					base_q       <= base_cur;
					cnt_q        <= cnt_cur;
					j_q          <= '0;
					k_q          <= '0;
					found_q      <= 1'b0;
					first_q      <= 1'b1;
					mode_q       <= (op_q == mslbs_pkg::OP_RSORTED) ? mslbs_pkg::SCAN_SORT
					                                                 : mslbs_pkg::SCAN_FIND;
					res_status_q <= exec_status;
					res_data_q   <= exec_count ? 32'(cnt_cur) : '0;
					res_dv_q     <= exec_count;
					res_last_q   <= 1'b1;
					res_next_q   <= S_IDLE;
					state_q      <= exec_next;
					if (exec_status == mslbs_pkg::ST_OK) begin
						if (op_q == mslbs_pkg::OP_CREATE) begin
							present_q[sidx]  <= 1'b1;
							cap_q[sidx]      <= CW'(opnd_q);
							cnt_meta_q[sidx] <= '0;
						end else begin
							case (op_q)
								mslbs_pkg::OP_APPEND: begin
									cnt_meta_q[sidx] <= cnt_cur + CW'(1);
								end
								mslbs_pkg::OP_DROP: begin
									cnt_meta_q[sidx] <= cnt_cur - CW'(1);
								end
								mslbs_pkg::OP_RESIZE: begin
									cap_q[sidx] <= CW'(nc);
									if (34'(cnt_cur) > nc) begin
										cnt_meta_q[sidx] <= CW'(nc);
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_SCAN: begin
					if (j_q < cnt_q) begin
						j_q     <= j_q + CW'(1);
						ridx_s1 <= j_q;
					end
					if (rv_s1) begin
						if (mode_q == mslbs_pkg::SCAN_FIND) begin
							if (!found_q && (ram_rdata == opnd_q)) begin
								found_q <= 1'b1;
								fidx_q  <= ridx_s1;
							end
						end else if (mode_q == mslbs_pkg::SCAN_SORT) begin
							if (cand && better) begin
								found_q    <= 1'b1;
								best_v_q   <= ram_rdata;
								best_idx_q <= ridx_s1;
							end
						end
					end else if (j_q >= cnt_q) begin
						case (mode_q)
							mslbs_pkg::SCAN_FIND: begin
								if (found_q) begin
									mode_q <= mslbs_pkg::SCAN_SHIFT;
									j_q    <= fidx_q + CW'(1);
								end else begin
									res_status_q <= mslbs_pkg::ST_NOT_FOUND;
									state_q      <= S_EMIT;
								end
							end
							mslbs_pkg::SCAN_SHIFT: begin
								cnt_meta_q[sidx] <= cnt_q - CW'(1);
								state_q          <= S_EMIT;
							end
							default: begin
								res_data_q <= best_v_q;
								res_dv_q   <= 1'b1;
								res_last_q <= (k_q + CW'(1) == cnt_q);
								res_next_q <= (k_q + CW'(1) == cnt_q) ? S_IDLE : S_SCAN;
								prev_v_q   <= best_v_q;
								prev_idx_q <= best_idx_q;
								first_q    <= 1'b0;
								found_q    <= 1'b0;
								k_q        <= k_q + CW'(1);
								j_q        <= '0;
								state_q    <= S_EMIT;
							end
						endcase
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					res_data_q <= ram_rdata;
					res_dv_q   <= 1'b1;
					res_last_q <= (k_q + CW'(1) == cnt_q);
					res_next_q <= (k_q + CW'(1) == cnt_q) ? S_IDLE : S_RD_ISSUE;
					k_q        <= k_q + CW'(1);
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						m_tdata_q  <= res_data_q;
						m_tuser_q  <= {res_dv_q, res_status_q};
						m_tlast_q  <= res_last_q;
						state_q    <= res_next_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// one operation in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && pos_ok && present_cur |-> cnt_cur <= cap_cur)
		else $error("slot count above capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> j_q <= cnt_q)
		else $error("scan index past count");

	a_ram_rw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("RAM read and write to one word");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && out_free |=> m_tvalid)
		else $error("result not placed");

endmodule
